// ===== hw/rtl/leg_inverse_kinematics_assert.svh =====
// assertion helpers for the leg inverse kinematics block
`ifndef LEG_INVERSE_KINEMATICS_ASSERT_SVH
`define LEG_INVERSE_KINEMATICS_ASSERT_SVH

// plain clocked check, ignored while in reset
`define LIK_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// consequent must hold exactly one pipeline latency after the antecedent
`define LIK_ASSERT_LAT(name, ante, cons, msg) \
  `LIK_ASSERT(name, (ante) |-> ##(LIK_LATENCY) (cons), msg)

`endif

// ===== hw/rtl/lik_pkg.sv =====
`default_nettype none
package lik_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int CORDIC_N = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;

  localparam int CW  = 34;  // cordic vector width
  localparam int AW  = 27;  // angle width, 1/65536 degree
  localparam int SW  = 58;  // square root radicand width
  localparam int DW  = 48;  // divider remainder width
  localparam int QW  = 28;  // quotient width
  localparam int STW = 5;   // step index width

  localparam logic signed [AW-1:0] DEG90  = AW'(5898240);
  localparam logic signed [AW-1:0] DEG180 = AW'(11796480);
  localparam logic [28:0] ONE_Q28 = 29'h1000_0000;

  localparam logic [1:0] CFG_UPPER = 2'd0;
  localparam logic [1:0] CFG_LOWER = 2'd1;
  localparam logic [1:0] CFG_SIDE  = 2'd2;

  localparam logic [14:0] UPPER_RST = 15'd1600;
  localparam logic [14:0] LOWER_RST = 15'd1600;
  localparam logic [14:0] SIDE_RST  = 15'd640;

  // pipeline stage positions
  localparam int K_H    = 1;
  localparam int H_N    = 16;
  localparam int K_SIDE = K_H + H_N + 1;
  localparam int SD_N   = 21;
  localparam int K_SD   = K_SIDE + SD_N + 1;
  localparam int K_R    = K_SD + 1;
  localparam int K_SQ   = K_R + 1;
  localparam int K_R3SQ = K_SQ + 1;
  localparam int R3_N   = 23;
  localparam int K_R3   = K_R3SQ + R3_N + 1;
  localparam int K_SAT  = K_R3 + 1;
  localparam int AC_N   = QW;
  localparam int K_C    = K_SAT + AC_N + 1;
  localparam int K_CSQ  = K_C + 1;
  localparam int S_N    = 29;
  localparam int K_S    = K_CSQ + S_N + 1;
  localparam int K_LAST = K_S + CORDIC_N;
  localparam int LIK_LATENCY = K_LAST + 2;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [AW-1:0] ang;
  } cordic_t;

  typedef struct packed {
    logic [SW-1:0] v;
    logic [SW-1:0] r;
  } sqrt_t;

  typedef struct packed {
    logic [DW-1:0] rem;
    logic [DW-1:0] low;
    logic [DW-1:0] den;
    logic [QW-1:0] q;
  } div_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic               flag;
    logic [31:0]        yz2;
    logic [15:0]        h;
    logic [37:0]        dnum;
    logic [16:0]        dden;
    logic signed [22:0] side;
    logic signed [23:0] r1;
    logic signed [21:0] r2;
    logic [45:0]        r1sq;
    logic [45:0]        r2sq;
    logic [45:0]        r3sq;
    logic [22:0]        r3;
    logic signed [47:0] num2;
    logic signed [47:0] num1;
    logic [47:0]        den2;
    logic [47:0]        den1;
    logic [47:0]        mag2;
    logic [47:0]        mag1;
    logic               sat2;
    logic               sat1;
    logic               neg2;
    logic               neg1;
    logic [28:0]        c2;
    logic [28:0]        c1;
    logic [56:0]        rad2;
    logic [56:0]        rad1;
    logic [28:0]        s2;
    logic [28:0]        s1;
  } ctx_t;

  // atan(2^-i) in 1/65536 degree
  function automatic logic signed [AW-1:0] lik_atan(input logic [STW-1:0] i);
    logic signed [AW-1:0] a;
    unique case (i)
      5'd0:  a = AW'(2949120);
      5'd1:  a = AW'(1740967);
      5'd2:  a = AW'(919879);
      5'd3:  a = AW'(466945);
      5'd4:  a = AW'(234379);
      5'd5:  a = AW'(117304);
      5'd6:  a = AW'(58666);
      5'd7:  a = AW'(29335);
      5'd8:  a = AW'(14668);
      5'd9:  a = AW'(7334);
      5'd10: a = AW'(3667);
      5'd11: a = AW'(1833);
      5'd12: a = AW'(917);
      5'd13: a = AW'(458);
      5'd14: a = AW'(229);
      5'd15: a = AW'(115);
      5'd16: a = AW'(57);
      5'd17: a = AW'(29);
      5'd18: a = AW'(14);
      5'd19: a = AW'(7);
      5'd20: a = AW'(4);
      5'd21: a = AW'(2);
      5'd22: a = AW'(1);
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/lik_cordic_cell.sv =====
`default_nettype none
module lik_cordic_cell import lik_pkg::*; (
  input  wire logic           clk_i,
  input  wire cordic_t        d_i,
  input  wire logic [STW-1:0] step_i,
  output cordic_t             d_o
);

  cordic_t cell_d, cell_q;
  logic signed [CW-1:0] dx, dy;

  always_comb begin
    dx = d_i.y >>> step_i;
    dy = d_i.x >>> step_i;
    cell_d = d_i;
    // rotate toward the x axis
    if (d_i.y > 0) begin
      cell_d.x   = d_i.x + dx;
      cell_d.y   = d_i.y - dy;
      cell_d.ang = d_i.ang + lik_atan(step_i);
    end else begin
      cell_d.x   = d_i.x - dx;
      cell_d.y   = d_i.y + dy;
      cell_d.ang = d_i.ang - lik_atan(step_i);
    end
  end

  always_ff @(posedge clk_i) begin
    cell_q <= cell_d;
  end

  assign d_o = cell_q;

endmodule
`default_nettype wire

// ===== hw/rtl/lik_sqrt_cell.sv =====
`default_nettype none
module lik_sqrt_cell import lik_pkg::*; (
  input  wire logic           clk_i,
  input  wire sqrt_t          d_i,
  input  wire logic [STW-1:0] step_i,
  output sqrt_t               d_o
);

  sqrt_t cell_d, cell_q;
  logic [SW-1:0] bit_w;
  logic [SW:0]   trial;

  always_comb begin
    bit_w = SW'(1) << {step_i, 1'b0};
    trial = {1'b0, d_i.r} + {1'b0, bit_w};
    cell_d = d_i;
    if ({1'b0, d_i.v} >= trial) begin
      cell_d.v = d_i.v - trial[SW-1:0];
      cell_d.r = (d_i.r >> 1) + bit_w;
    end else begin
      cell_d.r = d_i.r >> 1;
    end
  end

  always_ff @(posedge clk_i) begin
    cell_q <= cell_d;
  end

  assign d_o = cell_q;

endmodule
`default_nettype wire

// ===== hw/rtl/lik_div_cell.sv =====
`default_nettype none
module lik_div_cell import lik_pkg::*; (
  input  wire logic clk_i,
  input  wire div_t d_i,
  output div_t      d_o
);

  div_t cell_d, cell_q;
  logic [DW-1:0] shifted;

  always_comb begin
    // bring down the next dividend bit
    shifted = {d_i.rem[DW-2:0], d_i.low[DW-1]};
    cell_d = d_i;
    cell_d.low = d_i.low << 1;
    if (shifted >= d_i.den) begin
      cell_d.rem = shifted - d_i.den;
      cell_d.q   = {d_i.q[QW-2:0], 1'b1};
    end else begin
      cell_d.rem = shifted;
      cell_d.q   = {d_i.q[QW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    cell_q <= cell_d;
  end

  assign d_o = cell_q;

endmodule
`default_nettype wire

// ===== hw/rtl/leg_inverse_kinematics.sv =====
// channel  | direction | handshake               | payload
// target   | in        | start_i, busy_o         | target_x_i, target_y_i, target_z_i
// result   | out       | done_o (strobe)         | hip_pitch_angle_o, knee_angle_o,
//          |           |                         | abduction_angle_o, unreachable_o
// config   | in        | cfg_valid_i, cfg_ready_o| cfg_index_i, cfg_data_i
//
// a fully pipelined chain of cordic, square root and divider cells: one target per cycle
// the path from accept to the done_o strobe runs through the sqrt, divide, sqrt,
// divide, sqrt and cordic cell rows in series
// busy_o stays low, so a target may be started in every cycle
// asynchronous reset empties the pipeline and loads the link length defaults
// results are shown for one cycle only; the receiver cannot stall them
`default_nettype none
module leg_inverse_kinematics import lik_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  output logic                    busy_o,
  input  wire logic signed [15:0] target_x_i,
  input  wire logic signed [15:0] target_y_i,
  input  wire logic signed [15:0] target_z_i,
  output logic                    done_o,
  output logic signed [15:0]      hip_pitch_angle_o,
  output logic signed [15:0]      knee_angle_o,
  output logic signed [15:0]      abduction_angle_o,
  output logic                    unreachable_o,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [1:0]         cfg_index_i,
  input  wire logic [14:0]        cfg_data_i
);

  function automatic logic [15:0] to_out(input logic signed [AW-1:0] a);
    logic signed [AW-1:0] s;
    s = a + AW'(512);
    return s[25:10];
  endfunction

  logic accept;
  logic [14:0] l1_q, l2_q, l3_q;
  logic [29:0] sq1_q, sq2_q, l12_q;
  ctx_t ctx_d [K_LAST+1];
  ctx_t ctx_q [K_LAST+1];
  logic [K_LAST:0] vld_q;

  sqrt_t   h_c  [H_N+1];
  div_t    sd_c [SD_N+1];
  sqrt_t   r3_c [R3_N+1];
  div_t    a2_c [AC_N+1];
  div_t    a1_c [AC_N+1];
  sqrt_t   s2_c [S_N+1];
  sqrt_t   s1_c [S_N+1];
  cordic_t th_c [CORDIC_N+1];
  cordic_t ps_c [CORDIC_N+1];
  cordic_t p2_c [CORDIC_N+1];
  cordic_t p1_c [CORDIC_N+1];

  logic        done_q, unr_q;
  logic [15:0] hip_q, knee_q, abd_q;

  assign accept = start_i && !busy_o;
  assign busy_o = 1'b0;
  assign cfg_ready_o = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      l1_q <= UPPER_RST;
      l2_q <= LOWER_RST;
      l3_q <= SIDE_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_UPPER: l1_q <= cfg_data_i;
        CFG_LOWER: l2_q <= cfg_data_i;
        CFG_SIDE:  l3_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // link products follow the registers in the next cycle
  always_ff @(posedge clk_i) begin
    sq1_q <= 30'(l1_q) * 30'(l1_q);
    sq2_q <= 30'(l2_q) * 30'(l2_q);
    l12_q <= 30'(l1_q) * 30'(l2_q);
  end

  // cell rows
  assign h_c[0] = '{v: SW'(ctx_q[K_H].yz2), r: '0};
  for (genvar j = 0; j < H_N; j++) begin : g_h
    lik_sqrt_cell u_cell (.clk_i, .d_i(h_c[j]), .step_i(STW'(H_N-1-j)), .d_o(h_c[j+1]));
  end

  assign sd_c[0] = '{rem: DW'(ctx_q[K_SIDE].dnum[37:SD_N]),
                     low: {ctx_q[K_SIDE].dnum[SD_N-1:0], (DW-SD_N)'(0)},
                     den: DW'(ctx_q[K_SIDE].dden), q: '0};
  for (genvar j = 0; j < SD_N; j++) begin : g_sd
    lik_div_cell u_cell (.clk_i, .d_i(sd_c[j]), .d_o(sd_c[j+1]));
  end

  assign r3_c[0] = '{v: SW'(ctx_q[K_R3SQ].r3sq), r: '0};
  for (genvar j = 0; j < R3_N; j++) begin : g_r3
    lik_sqrt_cell u_cell (.clk_i, .d_i(r3_c[j]), .step_i(STW'(R3_N-1-j)), .d_o(r3_c[j+1]));
  end

  assign a2_c[0] = '{rem: ctx_q[K_SAT].mag2, low: '0, den: ctx_q[K_SAT].den2, q: '0};
  assign a1_c[0] = '{rem: ctx_q[K_SAT].mag1, low: '0, den: ctx_q[K_SAT].den1, q: '0};
  for (genvar j = 0; j < AC_N; j++) begin : g_ac
    lik_div_cell u_cell2 (.clk_i, .d_i(a2_c[j]), .d_o(a2_c[j+1]));
    lik_div_cell u_cell1 (.clk_i, .d_i(a1_c[j]), .d_o(a1_c[j+1]));
  end

  assign s2_c[0] = '{v: SW'(ctx_q[K_CSQ].rad2), r: '0};
  assign s1_c[0] = '{v: SW'(ctx_q[K_CSQ].rad1), r: '0};
  for (genvar j = 0; j < S_N; j++) begin : g_s
    lik_sqrt_cell u_cell2 (.clk_i, .d_i(s2_c[j]), .step_i(STW'(S_N-1-j)), .d_o(s2_c[j+1]));
    lik_sqrt_cell u_cell1 (.clk_i, .d_i(s1_c[j]), .step_i(STW'(S_N-1-j)), .d_o(s1_c[j+1]));
  end

  // cordic start vectors, denominator made positive
  always_comb begin
    logic signed [CW-1:0] tx, ty, px, py;
    tx = CW'(ctx_q[K_S].z);
    ty = CW'(ctx_q[K_S].y);
    if (ctx_q[K_S].z < 0) begin
      tx = -tx;
      ty = -ty;
    end
    px = CW'(ctx_q[K_S].r1);
    py = CW'(ctx_q[K_S].r2);
    if (ctx_q[K_S].r1 < 0) begin
      px = -px;
      py = -py;
    end
    th_c[0].x   = tx <<< 15;
    th_c[0].y   = ty <<< 15;
    th_c[0].ang = '0;
    ps_c[0].x   = px <<< 7;
    ps_c[0].y   = py <<< 7;
    ps_c[0].ang = '0;
    p2_c[0].x   = CW'({ctx_q[K_S].c2, 2'b00});
    p2_c[0].y   = CW'({ctx_q[K_S].s2, 2'b00});
    p2_c[0].ang = '0;
    p1_c[0].x   = CW'({ctx_q[K_S].c1, 2'b00});
    p1_c[0].y   = CW'({ctx_q[K_S].s1, 2'b00});
    p1_c[0].ang = '0;
  end

  for (genvar j = 0; j < CORDIC_N; j++) begin : g_cor
    lik_cordic_cell u_th (.clk_i, .d_i(th_c[j]), .step_i(STW'(j)), .d_o(th_c[j+1]));
    lik_cordic_cell u_ps (.clk_i, .d_i(ps_c[j]), .step_i(STW'(j)), .d_o(ps_c[j+1]));
    lik_cordic_cell u_p2 (.clk_i, .d_i(p2_c[j]), .step_i(STW'(j)), .d_o(p2_c[j+1]));
    lik_cordic_cell u_p1 (.clk_i, .d_i(p1_c[j]), .step_i(STW'(j)), .d_o(p1_c[j+1]));
  end

  // context carried beside the cells, filled in where each row ends
  always_comb begin
    logic signed [31:0] yy, zz;
    logic [15:0]        ay;
    logic [30:0]        prod;
    logic signed [22:0] l3s, ms;
    logic signed [23:0] z64;
    logic signed [47:0] r1w, r2w;
    logic [37:0]        lr;
    logic signed [47:0] r3w, sq1w, sq2w;
    logic [27:0]        q2, q1;
    logic [57:0]        csq2, csq1;

    for (int k = 1; k <= K_LAST; k++) begin
      ctx_d[k] = ctx_q[k-1];
    end
    ctx_d[0] = '0;
    ctx_d[0].x = target_x_i;
    ctx_d[0].y = target_y_i;
    ctx_d[0].z = target_z_i;

    yy = ctx_q[0].y * ctx_q[0].y;
    zz = ctx_q[0].z * ctx_q[0].z;
    ctx_d[K_H].yz2  = unsigned'(yy) + unsigned'(zz);
    ctx_d[K_H].flag = (ctx_q[0].z == 16'sd0);

    // rounded side offset term: (128p + h) / 2h
    ay   = ctx_q[K_SIDE-1].y[15] ? 16'(-ctx_q[K_SIDE-1].y) : 16'(ctx_q[K_SIDE-1].y);
    prod = 31'(l3_q) * 31'(ay);
    ctx_d[K_SIDE].h    = h_c[H_N].r[15:0];
    ctx_d[K_SIDE].dnum = {prod, 7'b0} + 38'(h_c[H_N].r[15:0]);
    ctx_d[K_SIDE].dden = {h_c[H_N].r[15:0], 1'b0};

    l3s = signed'({2'b00, l3_q, 6'b0});
    ms  = signed'({2'b00, sd_c[SD_N].q[20:0]});
    if (ctx_q[K_SD-1].z == 16'sd0) begin
      if (ctx_q[K_SD-1].y > 0) begin
        ctx_d[K_SD].side = l3s;
      end else if (ctx_q[K_SD-1].y < 0) begin
        ctx_d[K_SD].side = -l3s;
      end else begin
        ctx_d[K_SD].side = '0;
      end
    end else if ((ctx_q[K_SD-1].y < 0) != (ctx_q[K_SD-1].z < 0)) begin
      ctx_d[K_SD].side = -ms;
    end else begin
      ctx_d[K_SD].side = ms;
    end

    z64 = signed'({{2{ctx_q[K_R-1].z[15]}}, ctx_q[K_R-1].z, 6'b0});
    ctx_d[K_R].r1 = z64 - 24'(ctx_q[K_R-1].side);
    ctx_d[K_R].r2 = signed'({ctx_q[K_R-1].x, 6'b0});
    if (z64 == 24'(ctx_q[K_R-1].side)) begin
      ctx_d[K_R].flag = 1'b1;
    end

    r1w = 48'(ctx_q[K_SQ-1].r1);
    r2w = 48'(ctx_q[K_SQ-1].r2);
    ctx_d[K_SQ].r1sq = 46'(r1w * r1w);
    ctx_d[K_SQ].r2sq = 46'(r2w * r2w);

    ctx_d[K_R3SQ].r3sq = ctx_q[K_R3SQ-1].r1sq + ctx_q[K_R3SQ-1].r2sq;

    // law of cosines numerators and denominators
    lr   = 38'(l2_q) * 38'(r3_c[R3_N].r[22:0]);
    r3w  = signed'(48'(ctx_q[K_R3-1].r3sq));
    sq1w = signed'(48'(sq1_q));
    sq2w = signed'(48'(sq2_q));
    ctx_d[K_R3].r3   = r3_c[R3_N].r[22:0];
    ctx_d[K_R3].den2 = DW'({lr, 7'b0});
    ctx_d[K_R3].num2 = r3w + ((sq2w - sq1w) <<< 12);
    ctx_d[K_R3].num1 = ((sq1w + sq2w) <<< 12) - r3w;
    ctx_d[K_R3].den1 = DW'({l12_q, 13'b0});

    ctx_d[K_SAT].mag2 = ctx_q[K_SAT-1].num2[47] ? unsigned'(-ctx_q[K_SAT-1].num2)
                                                : unsigned'(ctx_q[K_SAT-1].num2);
    ctx_d[K_SAT].mag1 = ctx_q[K_SAT-1].num1[47] ? unsigned'(-ctx_q[K_SAT-1].num1)
                                                : unsigned'(ctx_q[K_SAT-1].num1);
    ctx_d[K_SAT].neg2 = ctx_q[K_SAT-1].num2[47];
    ctx_d[K_SAT].neg1 = ctx_q[K_SAT-1].num1[47];
    ctx_d[K_SAT].sat2 = (ctx_q[K_SAT-1].den2 == '0) ||
                        (ctx_d[K_SAT].mag2 >= ctx_q[K_SAT-1].den2);
    ctx_d[K_SAT].sat1 = (ctx_q[K_SAT-1].den1 == '0) ||
                        (ctx_d[K_SAT].mag1 >= ctx_q[K_SAT-1].den1);
    // flagged unreachable when either is out of range
    if ((ctx_q[K_SAT-1].den2 == '0) || (ctx_d[K_SAT].mag2 > ctx_q[K_SAT-1].den2) ||
        (ctx_q[K_SAT-1].den1 == '0) || (ctx_d[K_SAT].mag1 > ctx_q[K_SAT-1].den1)) begin
      ctx_d[K_SAT].flag = 1'b1;
    end

    q2 = a2_c[AC_N].q;
    q1 = a1_c[AC_N].q;
    ctx_d[K_C].c2   = ctx_q[K_C-1].sat2 ? ONE_Q28 : {1'b0, q2};
    ctx_d[K_C].c1   = ctx_q[K_C-1].sat1 ? ONE_Q28 : {1'b0, q1};
    ctx_d[K_C].neg2 = ctx_q[K_C-1].neg2 && (ctx_q[K_C-1].sat2 || (q2 != '0));
    ctx_d[K_C].neg1 = ctx_q[K_C-1].neg1 && (ctx_q[K_C-1].sat1 || (q1 != '0));

    csq2 = 58'(ctx_q[K_CSQ-1].c2) * 58'(ctx_q[K_CSQ-1].c2);
    csq1 = 58'(ctx_q[K_CSQ-1].c1) * 58'(ctx_q[K_CSQ-1].c1);
    ctx_d[K_CSQ].rad2 = {1'b1, 56'b0} - csq2[56:0];
    ctx_d[K_CSQ].rad1 = {1'b1, 56'b0} - csq1[56:0];

    ctx_d[K_S].s2 = s2_c[S_N].r[28:0];
    ctx_d[K_S].s1 = s1_c[S_N].r[28:0];
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k <= K_LAST; k++) begin
      ctx_q[k] <= ctx_d[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      done_q <= 1'b0;
    end else begin
      vld_q  <= {vld_q[K_LAST-1:0], accept};
      done_q <= vld_q[K_LAST];
    end
  end

  // final angle assembly
  always_ff @(posedge clk_i) begin
    logic signed [AW-1:0] th2, psi, phi2, phi1;
    if (ctx_q[K_LAST].z == 16'sd0) begin
      th2 = (ctx_q[K_LAST].y > 0) ? DEG90 : ((ctx_q[K_LAST].y < 0) ? -DEG90 : '0);
    end else begin
      th2 = th_c[CORDIC_N].ang;
    end
    if (ctx_q[K_LAST].r1 == '0) begin
      psi = (ctx_q[K_LAST].r2 > 0) ? DEG90 : ((ctx_q[K_LAST].r2 < 0) ? -DEG90 : '0);
    end else begin
      psi = ps_c[CORDIC_N].ang;
    end
    phi2 = ctx_q[K_LAST].neg2 ? DEG180 - p2_c[CORDIC_N].ang : p2_c[CORDIC_N].ang;
    phi1 = ctx_q[K_LAST].neg1 ? DEG180 - p1_c[CORDIC_N].ang : p1_c[CORDIC_N].ang;
    hip_q  <= to_out(phi1 - DEG180);
    knee_q <= to_out(phi2 - psi);
    abd_q  <= to_out(th2);
    unr_q  <= ctx_q[K_LAST].flag;
  end

  assign done_o            = done_q;
  assign hip_pitch_angle_o = signed'(hip_q);
  assign knee_angle_o      = signed'(knee_q);
  assign abduction_angle_o = signed'(abd_q);
  assign unreachable_o     = unr_q;

endmodule
`default_nettype wire

// ===== hw/rtl/lik_checker.sv =====
`default_nettype none
`include "leg_inverse_kinematics_assert.svh"
module lik_prop_checker import lik_pkg::*; (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               start_i,
  input wire logic               busy_o,
  input wire logic signed [15:0] target_z_i,
  input wire logic               done_o,
  input wire logic               unreachable_o
);

  // every accepted beat comes out after the fixed latency
  `LIK_ASSERT_LAT(a_fwd_latency, start_i && !busy_o, done_o, "result beat missing")
  // no result beat without a matching accept
  `LIK_ASSERT(a_back_latency, done_o |-> $past(start_i && !busy_o, LIK_LATENCY), "spurious result")
  // a zero downward coordinate is always flagged unreachable
  `LIK_ASSERT_LAT(a_zero_z, start_i && !busy_o && (target_z_i == 16'sd0), unreachable_o, "zero z")

endmodule

bind leg_inverse_kinematics lik_prop_checker u_lik_checker (.*);
`default_nettype wire
